// ----- rtl/trilin_pkg.sv -----
// Shared constants and types for the trilinear table interpolator.
// No dependencies.
`default_nettype none

package trilin_pkg;

  localparam int TABLE_AW = 14;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int DATA_W = 32;
  localparam int COORD_W = 16;
  localparam int STEP_W = 20;
  localparam int FRAC_W = 12;
  localparam int PROD_W = COORD_W + STEP_W;
  localparam int STEP_FRAC_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W = 5;

  localparam int DEF_ERR_POINTS = 16;
  localparam int DEF_SRC_POINTS = 32;
  localparam int DEF_LENS_POINTS = 32;

  localparam logic [STEP_W-1:0] INV_STEP_RESET = STEP_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERR_MIN       = 3'd0,
    CFG_ERR_INV_STEP  = 3'd1,
    CFG_SRC_MIN       = 3'd2,
    CFG_SRC_INV_STEP  = 3'd3,
    CFG_LENS_MIN      = 3'd4,
    CFG_LENS_INV_STEP = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_AXIS = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  // Sequencer schedule: corner reads at steps 0..7, lens blends issued at
  // 2,4,6,8, source blends at 7 and 11, error blend at 14, result at 17.
  localparam logic [CNT_W-1:0] AXIS_LAST   = 5'd3;
  localparam logic [CNT_W-1:0] READ_LAST   = 5'd7;
  localparam logic [CNT_W-1:0] HOLD0_A     = 5'd5;
  localparam logic [CNT_W-1:0] HOLD0_B     = 5'd9;
  localparam logic [CNT_W-1:0] HOLD1       = 5'd10;
  localparam logic [CNT_W-1:0] SRC_BLEND_A = 5'd7;
  localparam logic [CNT_W-1:0] SRC_BLEND_B = 5'd11;
  localparam logic [CNT_W-1:0] ERR_BLEND   = 5'd14;
  localparam logic [CNT_W-1:0] RUN_LAST    = 5'd17;

endpackage

`default_nettype wire

// ----- rtl/trilinear_table_interpolator_core.sv -----
// Trilinear interpolator over a 3-D table held in one single-port memory.
// Depends on trilin_pkg. Table write: no result, next item taken in the next cycle.
// Query: three grid indices from one shared 16x20 multiplier, then
// eight corner reads, one per cycle from the single memory port, into a 3-stage
// blend pipeline; done rises with the registered result (earlier when out of
// range); next item taken in the cycle done is high. Reset: sync, config to defaults.
`default_nettype none

module trilinear_table_interpolator_core #(
  parameter int ERR_POINTS  = trilin_pkg::DEF_ERR_POINTS,
  parameter int SRC_POINTS  = trilin_pkg::DEF_SRC_POINTS,
  parameter int LENS_POINTS = trilin_pkg::DEF_LENS_POINTS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  opcode,
  input  wire logic        [trilin_pkg::TABLE_AW-1:0] table_address,
  input  wire logic signed [trilin_pkg::DATA_W-1:0]   table_value,
  input  wire logic        [trilin_pkg::COORD_W-1:0]  source_z_err,
  input  wire logic        [trilin_pkg::COORD_W-1:0]  source_z,
  input  wire logic        [trilin_pkg::COORD_W-1:0]  lens_z,
  input  wire logic                                  cfg_write,
  input  wire logic        [trilin_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [trilin_pkg::STEP_W-1:0]   cfg_data,
  output logic                                       done,
  output logic signed      [trilin_pkg::DATA_W-1:0]   interp_value,
  output logic                                       out_of_range
);
  import trilin_pkg::*;

  localparam int XW = (ERR_POINTS > 1) ? $clog2(ERR_POINTS) : 1;
  localparam int YW = (SRC_POINTS > 1) ? $clog2(SRC_POINTS) : 1;
  localparam int ZW = (LENS_POINTS > 1) ? $clog2(LENS_POINTS) : 1;
  localparam int IW = PROD_W - STEP_FRAC_W - FRAC_W;
  localparam int DW = DATA_W + 1;
  localparam int MW = DW + FRAC_W + 1;

  // configuration
  logic [COORD_W-1:0] err_min, src_min, lens_min;
  logic [STEP_W-1:0]  err_inv_step, src_inv_step, lens_inv_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_min       <= '0;
      src_min       <= '0;
      lens_min      <= '0;
      err_inv_step  <= INV_STEP_RESET;
      src_inv_step  <= INV_STEP_RESET;
      lens_inv_step <= INV_STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ERR_MIN:       err_min       <= cfg_data[COORD_W-1:0];
        CFG_ERR_INV_STEP:  err_inv_step  <= cfg_data;
        CFG_SRC_MIN:       src_min       <= cfg_data[COORD_W-1:0];
        CFG_SRC_INV_STEP:  src_inv_step  <= cfg_data;
        CFG_LENS_MIN:      lens_min      <= cfg_data[COORD_W-1:0];
        CFG_LENS_INV_STEP: lens_inv_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             accept, wr_en, query_go;

  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign wr_en    = accept && (opcode == OP_WRITE);
  assign query_go = accept && (opcode == OP_QUERY);

  // axis index: multiply for axis cnt, evaluate axis cnt-1 from the registered product
  logic [COORD_W-1:0] q_err, q_src, q_lens;
  logic [COORD_W-1:0] mul_coord, mul_min;
  logic [STEP_W-1:0]  mul_inv;
  logic [COORD_W:0]   mul_diff;
  logic [PROD_W-1:0]  prod_r;
  logic               neg_r;
  logic [IW-1:0]      ev_i;
  logic [FRAC_W-1:0]  ev_f;
  logic               ev_fail, oor_r, fail_any;
  logic [XW-1:0]      x0;
  logic [YW-1:0]      y0;
  logic [ZW-1:0]      z0;
  logic [FRAC_W-1:0]  fx, fy, fz;

  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        mul_coord = q_err;
        mul_min   = err_min;
        mul_inv   = err_inv_step;
      end
      2'd1: begin
        mul_coord = q_src;
        mul_min   = src_min;
        mul_inv   = src_inv_step;
      end
      default: begin
        mul_coord = q_lens;
        mul_min   = lens_min;
        mul_inv   = lens_inv_step;
      end
    endcase
  end

  assign mul_diff = {1'b0, mul_coord} - {1'b0, mul_min};
  assign ev_i     = prod_r[PROD_W-1 -: IW];
  assign ev_f     = prod_r[STEP_FRAC_W +: FRAC_W];

  always_comb begin
    case (cnt[1:0])
      2'd1:    ev_fail = neg_r || (ev_i >= IW'(ERR_POINTS - 1));
      2'd2:    ev_fail = neg_r || (ev_i >= IW'(SRC_POINTS - 1));
      default: ev_fail = neg_r || (ev_i >= IW'(LENS_POINTS - 1));
    endcase
  end

  assign fail_any = oor_r || ev_fail;

  // corner addressing
  logic [XW-1:0]       xc;
  logic [YW-1:0]       yc;
  logic [ZW-1:0]       zc;
  logic [31:0]         addr_wide;
  logic [TABLE_AW-1:0] mem_addr;
  logic                rd_en;

  assign xc = x0 + XW'(cnt[2]);
  assign yc = y0 + YW'(cnt[1]);
  assign zc = z0 + ZW'(cnt[0]);
  assign addr_wide = (32'(xc) * 32'(SRC_POINTS) + 32'(yc)) * 32'(LENS_POINTS) + 32'(zc);
  assign mem_addr  = (state == S_IDLE) ? table_address : addr_wide[TABLE_AW-1:0];
  assign rd_en     = (state == S_RUN) && (cnt <= READ_LAST);

  // table memory, single port, registered read
  logic signed [DATA_W-1:0] grid_table [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata, prev_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_table[mem_addr] <= table_value;
    end else if (rd_en) begin
      rdata <= grid_table[mem_addr];
    end
  end

  // blend pipeline: r = a + floor(((b - a) * f + 2048) / 4096)
  logic signed [DATA_W-1:0] bl_a, bl_b, a1, a2, r3, h0, h1;
  logic        [FRAC_W-1:0] bl_f, f1;
  logic signed [DW-1:0]     d1;
  logic signed [MW-1:0]     p2;
  logic        [MW-1:0]     rnd_sum;

  always_comb begin
    bl_a = prev_word;
    bl_b = rdata;
    bl_f = fz;
    if (cnt == SRC_BLEND_A || cnt == SRC_BLEND_B) begin
      bl_a = h0;
      bl_b = r3;
      bl_f = fy;
    end else if (cnt == ERR_BLEND) begin
      bl_a = h1;
      bl_b = r3;
      bl_f = fx;
    end
  end

  assign rnd_sum = p2 + MW'(1 << (FRAC_W - 1));

  always_ff @(posedge clk) begin
    prev_word <= rdata;
    a1 <= bl_a;
    d1 <= {bl_b[DATA_W-1], bl_b} - {bl_a[DATA_W-1], bl_a};
    f1 <= bl_f;
    a2 <= a1;
    p2 <= d1 * $signed({1'b0, f1});
    r3 <= rnd_sum[FRAC_W +: DATA_W] + a2;
    if (state == S_RUN) begin
      if (cnt == HOLD0_A || cnt == HOLD0_B) begin
        h0 <= r3;
      end
      if (cnt == HOLD1) begin
        h1 <= r3;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (query_go) begin
      q_err  <= source_z_err;
      q_src  <= source_z;
      q_lens <= lens_z;
      oor_r  <= 1'b0;
    end
    if (state == S_AXIS) begin
      prod_r <= mul_diff[COORD_W-1:0] * mul_inv;
      neg_r  <= mul_diff[COORD_W];
      if (cnt != '0) begin
        oor_r <= fail_any;
        case (cnt[1:0])
          2'd1: begin
            x0 <= ev_i[XW-1:0];
            fx <= ev_f;
          end
          2'd2: begin
            y0 <= ev_i[YW-1:0];
            fy <= ev_f;
          end
          default: begin
            z0 <= ev_i[ZW-1:0];
            fz <= ev_f;
          end
        endcase
      end
      if (cnt == AXIS_LAST && fail_any) begin
        interp_value <= '0;
        out_of_range <= 1'b1;
      end
    end
    if (state == S_RUN && cnt == RUN_LAST) begin
      interp_value <= r3;
      out_of_range <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (query_go) begin
            state <= S_AXIS;
          end
        end
        S_AXIS: begin
          if (cnt == AXIS_LAST) begin
            cnt <= '0;
            if (fail_any) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_RUN;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_RUN: begin
          if (cnt == RUN_LAST) begin
            cnt   <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/interp_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for trilinear_table_interpolator_core: mirrors the table and axis
// registers, predicts every lookup and checks each done strobe. Depends on trilin_pkg.
module interp_checker #(
  parameter int ERR_POINTS  = trilin_pkg::DEF_ERR_POINTS,
  parameter int SRC_POINTS  = trilin_pkg::DEF_SRC_POINTS,
  parameter int LENS_POINTS = trilin_pkg::DEF_LENS_POINTS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic                                   opcode,
  input  logic        [trilin_pkg::TABLE_AW-1:0]  table_address,
  input  logic signed [trilin_pkg::DATA_W-1:0]    table_value,
  input  logic        [trilin_pkg::COORD_W-1:0]   source_z_err,
  input  logic        [trilin_pkg::COORD_W-1:0]   source_z,
  input  logic        [trilin_pkg::COORD_W-1:0]   lens_z,
  input  logic                                   cfg_write,
  input  logic        [trilin_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [trilin_pkg::STEP_W-1:0]    cfg_data,
  input  logic                                   done,
  input  logic signed [trilin_pkg::DATA_W-1:0]    interp_value,
  input  logic                                   out_of_range,
  output int                                     outstanding,
  output int                                     mismatches,
  output int                                     oor_results
);
  import trilin_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam longint FRAC_ONE = longint'(1) << FRAC_W;

  typedef struct packed {
    logic              hit;
    logic [7:0]        slot;
    logic [FRAC_W-1:0] frac;
  } axis_pos_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              oor;
  } lookup_result_t;

  logic signed [DATA_W-1:0] grid_copy [TABLE_DEPTH];
  logic [COORD_W-1:0] err_origin, src_origin, lens_origin;
  logic [STEP_W-1:0]  err_step, src_step, lens_step;
  lookup_result_t     lookup_q [$];

  function automatic axis_pos_t locate(input logic [COORD_W-1:0] coord, origin,
                                       input logic [STEP_W-1:0] step, input int points);
    logic [PROD_W-1:0] scaled;
    axis_pos_t pos;
    pos = '0;
    if (coord >= origin) begin
      scaled = (PROD_W'(coord - origin) * PROD_W'(step)) >> STEP_FRAC_W;
      if ((scaled >> FRAC_W) + 1 < points) begin
        pos.hit  = 1'b1;
        pos.slot = 8'(scaled >> FRAC_W);
        pos.frac = scaled[FRAC_W-1:0];
      end
    end
    return pos;
  endfunction

  // a*(1-f) + b*f, round half up, floor division
  function automatic longint lerp_round(input longint lo, hi, frac);
    longint acc;
    acc = lo * (FRAC_ONE - frac) + hi * frac + FRAC_ONE / 2;
    return acc >>> FRAC_W;
  endfunction

  function automatic longint corner_word(input int x, y, z);
    logic [TABLE_AW-1:0] addr;
    addr = TABLE_AW'((x * SRC_POINTS + y) * LENS_POINTS + z);
    return longint'(grid_copy[addr]);
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [COORD_W-1:0] e_c, s_c, l_c);
    axis_pos_t pe, ps, pl;
    longint fx, fy, fz, c00, c01, c10, c11, e0, e1;
    int x, y, z;
    lookup_result_t r;
    pe = locate(e_c, err_origin, err_step, ERR_POINTS);
    ps = locate(s_c, src_origin, src_step, SRC_POINTS);
    pl = locate(l_c, lens_origin, lens_step, LENS_POINTS);
    r = '0;
    r.oor = 1'b1;
    if (pe.hit && ps.hit && pl.hit) begin
      x = int'(pe.slot);
      y = int'(ps.slot);
      z = int'(pl.slot);
      fx = longint'(pe.frac);
      fy = longint'(ps.frac);
      fz = longint'(pl.frac);
      c00 = lerp_round(corner_word(x, y, z), corner_word(x, y, z + 1), fz);
      c01 = lerp_round(corner_word(x, y + 1, z), corner_word(x, y + 1, z + 1), fz);
      c10 = lerp_round(corner_word(x + 1, y, z), corner_word(x + 1, y, z + 1), fz);
      c11 = lerp_round(corner_word(x + 1, y + 1, z), corner_word(x + 1, y + 1, z + 1), fz);
      e0 = lerp_round(c00, c01, fy);
      e1 = lerp_round(c10, c11, fy);
      r.value = DATA_W'(lerp_round(e0, e1, fx));
      r.oor = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lookup_result_t want;
    if (rst) begin
      err_origin = '0;
      src_origin = '0;
      lens_origin = '0;
      err_step = INV_STEP_RESET;
      src_step = INV_STEP_RESET;
      lens_step = INV_STEP_RESET;
      lookup_q.delete();
      mismatches = 0;
      oor_results = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ERR_MIN:       err_origin = cfg_data[COORD_W-1:0];
          CFG_ERR_INV_STEP:  err_step = cfg_data;
          CFG_SRC_MIN:       src_origin = cfg_data[COORD_W-1:0];
          CFG_SRC_INV_STEP:  src_step = cfg_data;
          CFG_LENS_MIN:      lens_origin = cfg_data[COORD_W-1:0];
          CFG_LENS_INV_STEP: lens_step = cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (out_of_range)
          oor_results++;
        if (lookup_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result value=%0d out_of_range=%0b",
                     $time, interp_value, out_of_range);
        end else begin
          want = lookup_q.pop_front();
          if (interp_value !== want.value || out_of_range !== want.oor) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: mismatch: expected value=%0d oor=%0b, got value=%0d oor=%0b",
                       $time, $signed(want.value), want.oor, interp_value, out_of_range);
          end
        end
      end
      if (start && !busy) begin
        if (opcode == OP_WRITE)
          grid_copy[table_address] = table_value;
        else
          lookup_q.push_back(predict_lookup(source_z_err, source_z, lens_z));
      end
    end
    outstanding <= lookup_q.size();
  end

endmodule

// ----- tb/tb_trilinear_table_interpolator_core.sv -----
`timescale 1ns / 1ps
// Top of the trilinear_table_interpolator_core bench: table fill, directed and random
// command traffic over several axis settings, watchdog and verdict.
// Depends on trilin_pkg, interp_checker and the core RTL.
module tb_trilinear_table_interpolator_core;
  import trilin_pkg::*;

  localparam int HANG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int ITEMS_PER_SETTING = 170;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  opcode_t opcode = OP_WRITE;
  logic [TABLE_AW-1:0] table_address = '0;
  logic signed [DATA_W-1:0] table_value = '0;
  logic [COORD_W-1:0] source_z_err = '0;
  logic [COORD_W-1:0] source_z = '0;
  logic [COORD_W-1:0] lens_z = '0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0] cfg_data = '0;
  logic done;
  logic signed [DATA_W-1:0] interp_value;
  logic out_of_range;

  int outstanding, mismatches, oor_results;
  int quiet_cycles = 0;
  int writes = 0, queries = 0, settings = 1;
  int burst_left = 0;
  bit paced = 1'b0;
  logic [COORD_W-1:0] err_org = '0, src_org = '0, lens_org = '0;
  logic [STEP_W-1:0] err_stp = INV_STEP_RESET;
  logic [STEP_W-1:0] src_stp = INV_STEP_RESET;
  logic [STEP_W-1:0] lens_stp = INV_STEP_RESET;
  bit written_map [TABLE_DEPTH];

  trilinear_table_interpolator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .table_address(table_address), .table_value(table_value),
    .source_z_err(source_z_err), .source_z(source_z), .lens_z(lens_z),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .interp_value(interp_value), .out_of_range(out_of_range)
  );

  interp_checker scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .table_address(table_address), .table_value(table_value),
    .source_z_err(source_z_err), .source_z(source_z), .lens_z(lens_z),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .interp_value(interp_value), .out_of_range(out_of_range),
    .outstanding(outstanding), .mismatches(mismatches), .oor_results(oor_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("trilinear_table_interpolator_core test failed");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return DATA_W'($urandom_range(0, 255)) - DATA_W'(128);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // log-scaled offsets above the origin, some below it, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] origin);
    int unsigned bits;
    int unsigned reach;
    case ($urandom_range(0, 5))
      0: return COORD_W'($urandom);
      1: begin
        if (origin > 0)
          return origin - COORD_W'($urandom_range(1, origin));
        return '0;
      end
      default: begin
        bits = $urandom_range(0, COORD_W);
        reach = origin + $urandom_range(0, (1 << bits) - 1);
        return reach > COORD_MAX ? COORD_MAX : COORD_W'(reach);
      end
    endcase
  endfunction

  // grid index of one axis; false when the query leaves the grid on it
  function automatic bit axis_hit(input logic [COORD_W-1:0] coord, origin,
                                  input logic [STEP_W-1:0] step, input int points,
                                  output int idx);
    logic [PROD_W-1:0] scaled;
    idx = 0;
    if (coord < origin)
      return 1'b0;
    scaled = PROD_W'(coord - origin) * PROD_W'(step);
    idx = int'(scaled >> (STEP_FRAC_W + FRAC_W));
    return (idx + 1 < points);
  endfunction

  function automatic logic [TABLE_AW-1:0] cube_addr(input int n);
    return TABLE_AW'(((n >> 2) * DEF_SRC_POINTS + ((n >> 1) & 1)) * DEF_LENS_POINTS + (n & 1));
  endfunction

  task automatic issue(input opcode_t op, input logic [TABLE_AW-1:0] addr,
                       input logic [DATA_W-1:0] word,
                       input logic [COORD_W-1:0] e_c, s_c, l_c);
    int gap;
    start <= 1'b1;
    opcode <= op;
    table_address <= addr;
    table_value <= word;
    source_z_err <= e_c;
    source_z <= s_c;
    lens_z <= l_c;
    do @(posedge clk); while (busy);
    if (op == OP_WRITE) begin
      writes++;
      written_map[addr] = 1'b1;
    end else begin
      queries++;
    end
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic store(input logic [TABLE_AW-1:0] addr, input logic [DATA_W-1:0] word);
    issue(OP_WRITE, addr, word, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // corners of an on-grid lookup that were never written get a word first
  task automatic lookup(input logic [COORD_W-1:0] e_c, s_c, l_c);
    int x, y, z;
    bit hx, hy, hz;
    logic [TABLE_AW-1:0] addr;
    hx = axis_hit(e_c, err_org, err_stp, DEF_ERR_POINTS, x);
    hy = axis_hit(s_c, src_org, src_stp, DEF_SRC_POINTS, y);
    hz = axis_hit(l_c, lens_org, lens_stp, DEF_LENS_POINTS, z);
    if (hx && hy && hz) begin
      for (int n = 0; n < 8; n++) begin
        addr = TABLE_AW'(((x + (n >> 2)) * DEF_SRC_POINTS + y + ((n >> 1) & 1))
                         * DEF_LENS_POINTS + z + (n & 1));
        if (!written_map[addr])
          store(addr, pick_word());
      end
    end
    issue(OP_QUERY, TABLE_AW'($urandom), DATA_W'($urandom), e_c, s_c, l_c);
  endtask

  // writes cause no result, so idle also needs a drain after the last lookup
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_axes(input logic [STEP_W-1:0] e_min, e_step, s_min, s_step,
                              l_min, l_step);
    wait_idle();
    cfg_put(CFG_ERR_MIN, e_min);
    cfg_put(CFG_ERR_INV_STEP, e_step);
    cfg_put(CFG_SRC_MIN, s_min);
    cfg_put(CFG_SRC_INV_STEP, s_step);
    cfg_put(CFG_LENS_MIN, l_min);
    cfg_put(CFG_LENS_INV_STEP, l_step);
    cfg_put(CFG_SPARE_LO, STEP_W'($urandom));
    cfg_put(CFG_SPARE_HI, STEP_W'($urandom));
    cfg_write <= 1'b0;
    err_org = e_min[COORD_W-1:0];
    src_org = s_min[COORD_W-1:0];
    lens_org = l_min[COORD_W-1:0];
    err_stp = e_step;
    src_stp = s_step;
    lens_stp = l_step;
    settings++;
  endtask

  task automatic run_traffic();
    int stop_at;
    stop_at = writes + queries + ITEMS_PER_SETTING;
    while (writes + queries < stop_at) begin
      if ($urandom_range(0, 9) < 3)
        store(TABLE_AW'($urandom), pick_word());
      else
        lookup(pick_coord(err_org), pick_coord(src_org), pick_coord(lens_org));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    start <= 1'b0;
    paced = 1'b1;
    repeat (3) @(posedge clk);

    // saturated corners, both signs, half, near-full and zero fractions, off-grid points
    for (int n = 0; n < 8; n++)
      store(cube_addr(n), WORD_MAX);
    lookup(16'h0800, 16'h0800, 16'h0800);
    for (int n = 0; n < 8; n++)
      store(cube_addr(n), WORD_MIN);
    lookup(16'h0FFF, 16'h0FFF, 16'h0FFF);
    lookup('0, '0, '0);
    lookup(16'hF000, '0, '0);
    lookup(COORD_MAX, COORD_MAX, COORD_MAX);

    run_traffic();
    program_axes(20'h01000, 20'd2048, 20'h00800, 20'd1024, 20'h02000, 20'd512);
    run_traffic();
    program_axes('0, STEP_MAX, '0, STEP_MAX, '0, STEP_MAX);
    run_traffic();
    program_axes(STEP_W'($urandom), '0, STEP_W'($urandom), '0, STEP_W'($urandom), '0);
    run_traffic();
    program_axes(STEP_W'(COORD_MAX), STEP_W'($urandom), STEP_W'(COORD_MAX), STEP_W'($urandom),
                 STEP_W'(COORD_MAX), STEP_W'($urandom));
    run_traffic();
    program_axes(STEP_W'($urandom_range(0, 32768)), STEP_W'($urandom_range(256, 8192)),
                 STEP_W'($urandom_range(0, 32768)), STEP_W'($urandom_range(256, 8192)),
                 STEP_W'($urandom_range(0, 32768)), STEP_W'($urandom_range(256, 8192)));
    run_traffic();
    program_axes(STEP_W'($urandom), STEP_W'($urandom), STEP_W'($urandom),
                 STEP_W'($urandom), STEP_W'($urandom), STEP_W'($urandom));
    run_traffic();
    wait_idle();

    $display("Covered %0d table writes and %0d lookups (%0d off grid) over %0d axis settings,",
             writes, queries, oor_results, settings);
    $display("including saturated corners, zero and full-scale steps and origins at both ends.");
    if (mismatches == 0)
      $display("trilinear_table_interpolator_core test passed");
    else
      $display("trilinear_table_interpolator_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/trilin_pkg.sv
rtl/trilinear_table_interpolator_core.sv
tb/interp_checker.sv
tb/tb_trilinear_table_interpolator_core.sv
